### rtl/blvd_pkg.sv
// Shared operation codes, control struct and widths for the bounded list.
package blvd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CountW = 5;

  typedef enum logic [KindW-1:0] {
    KindInsFront = 3'd0,
    KindInsBack  = 3'd1,
    KindDelFront = 3'd2,
    KindDelBack  = 3'd3,
    KindDelValue = 3'd4
  } kind_e;

  // Per-cycle command broadcast to every cell, already qualified by the handshake.
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic del_front;
    logic del_value;
  } cell_ctrl_t;

endpackage

### rtl/blvd_cell.sv
// One list position: holds an entry, compares it, and shifts with its neighbours.
module blvd_cell import blvd_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  input  logic             found_i,
  output logic             found_o,
  output logic [DataW-1:0] data_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic [DataW-1:0] data_q, data_d;
  logic             occ;
  logic             match;

  assign occ     = IdxC < count_i;
  assign match   = occ && (data_q == value_i);
  // first match at or before this cell: this cell and all behind it close the gap
  assign found_o = found_i | match;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_front) begin
      data_d = left_i;
    end else if (ctrl_i.ins_back && (IdxC == count_i)) begin
      data_d = value_i;
    end else if (ctrl_i.del_front || (ctrl_i.del_value && found_o)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### rtl/bounded_list_with_value_delete.sv
// A result word appears in the cycle after its input word is accepted.
// One operation per cycle while results are taken; all cells compare and shift
// in parallel; the first-match flag ripples along all cells within the cycle.
// The output register frees the input side whenever it is empty or being taken.
// Reset clears the entry count and the output valid; entry data is not reset.
module bounded_list_with_value_delete import blvd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KindW-1:0]  kind_i,
  input  logic signed [DataW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] entry_count_o,
  output logic              is_empty_o,
  output logic              took_effect_o,
  output logic              overflow_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q;
  logic [CountW-1:0] entry_count_q;
  logic             is_empty_q, took_q, ovf_q;
  logic             took_d, ovf_d;
  logic             accept;
  logic             full, empty, found_any;
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] cell_data [DEPTH];
  logic [DEPTH:0]   found;
  logic [CntW+CountW-1:0] cnt_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = count_q == DepthC;
  assign empty      = count_q == '0;
  assign found[0]   = 1'b0;
  assign found_any  = found[DEPTH];

  always_comb begin
    ctrl   = '0;
    took_d = 1'b0;
    ovf_d  = 1'b0;
    count_d = count_q;
    case (kind_i)
      KindInsFront: begin
        ovf_d  = full;
        took_d = !full;
        ctrl.ins_front = accept && !full;
      end
      KindInsBack: begin
        ovf_d  = full;
        took_d = !full;
        ctrl.ins_back = accept && !full;
      end
      KindDelFront: begin
        took_d = !empty;
        ctrl.del_front = accept && !empty;
      end
      KindDelBack: begin
        took_d = !empty;
      end
      KindDelValue: begin
        took_d = found_any;
        ctrl.del_value = accept;
      end
      default: begin
        took_d = 1'b0;
      end
    endcase
    if (took_d) begin
      if ((kind_i == KindInsFront) || (kind_i == KindInsBack)) begin
        count_d = count_q + CntW'(1);
      end else begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, count_d};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = value_i;
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = cell_data[g];
    end else begin : g_body
      assign right_w = cell_data[g+1];
    end
    blvd_cell #(.Idx(g), .CntW(CntW)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_count_q <= cnt_ext[CountW-1:0];
      is_empty_q    <= count_d == '0;
      took_q        <= took_d && accept;
      ovf_q         <= ovf_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign took_effect_o = took_q;
  assign overflow_o    = ovf_q;

endmodule

### rtl/blvd_checker.sv
// Port-level checks for the bounded list, bound to the top level.
module blvd_checker import blvd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CountW-1:0] entry_count_o,
  input logic              is_empty_o,
  input logic              took_effect_o,
  input logic              overflow_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_count_o)
      && $stable(took_effect_o) && $stable(overflow_o))
    else $error("result word changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted word");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_ovf_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !took_effect_o && !is_empty_o)
    else $error("overflow reported with effect or on empty list");

endmodule

bind bounded_list_with_value_delete blvd_checker u_blvd_checker (.*);

### tb/bounded_list_with_value_delete_tb.sv
// Self-checking testbench for the bounded list with value delete.
`timescale 1ns / 1ps

module bounded_list_with_value_delete_tb;
  import blvd_pkg::*;

  localparam int unsigned ListDepth = 16;
  localparam int unsigned StallLimit = 4000;
  localparam logic [KindW-1:0] KindSpareA = 3'd5;
  localparam logic [KindW-1:0] KindSpareB = 3'd6;
  localparam logic [KindW-1:0] KindSpareC = 3'd7;

  typedef struct {
    logic [KindW-1:0]        kind;
    logic signed [DataW-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic [CountW-1:0] entry_count;
    logic              is_empty;
    logic              took_effect;
    logic              overflow;
  } list_status_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [KindW-1:0]        kind_i = '0;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CountW-1:0]       entry_count_o;
  logic                    is_empty_o;
  logic                    took_effect_o;
  logic                    overflow_o;

  list_cmd_t    pending_cmds[$];
  list_status_t expected_status[$];

  // Shadow copy of the list contents
  logic signed [DataW-1:0] held_vals [ListDepth];
  int                      held = 0;

  bit failed = 1'b0;
  int words_in = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int idle_cycles = 0;

  bounded_list_with_value_delete #(
    .DEPTH(ListDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .took_effect_o(took_effect_o),
    .overflow_o   (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  // Remove one entry and close the gap behind it.
  function void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < held; i++) held_vals[i] = held_vals[i + 1];
    held--;
  endfunction

  function list_status_t apply_list_op(input logic [KindW-1:0] op,
                                       input logic signed [DataW-1:0] v);
    list_status_t st;
    int pos;
    st.took_effect = 1'b0;
    st.overflow = 1'b0;
    case (op)
      KindInsFront, KindInsBack: begin
        if (held >= ListDepth) begin
          st.overflow = 1'b1;
        end else begin
          if (op == KindInsFront) begin
            for (pos = held; pos > 0; pos--) held_vals[pos] = held_vals[pos - 1];
            held_vals[0] = v;
          end else begin
            held_vals[held] = v;
          end
          held++;
          st.took_effect = 1'b1;
        end
      end
      KindDelFront: begin
        if (held > 0) begin
          drop_entry(0);
          st.took_effect = 1'b1;
        end
      end
      KindDelBack: begin
        if (held > 0) begin
          held--;
          st.took_effect = 1'b1;
        end
      end
      KindDelValue: begin
        pos = 0;
        while (pos < held && !st.took_effect) begin
          if (held_vals[pos] == v) begin
            drop_entry(pos);
            st.took_effect = 1'b1;
          end
          pos++;
        end
      end
      default: ;
    endcase
    st.entry_count = held[CountW-1:0];
    st.is_empty = (held == 0);
    return st;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm run with none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(15, 40);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_cmd(input logic [KindW-1:0] k, input logic signed [DataW-1:0] v);
    list_cmd_t c;
    c.kind = k;
    c.value = v;
    pending_cmds.push_back(c);
  endtask

  // Driver: hold a word until taken, then pause or offer the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= '0;
      value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(apply_list_op(kind_i, value_i));
        void'(pending_cmds.pop_front());
        words_in <= words_in + 1;
        send_gap = next_gap(send_calm);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_valid_i <= 1'b1;
        kind_i <= pending_cmds[0].kind;
        value_i <= pending_cmds[0].value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the list has seen some traffic.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 120) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each taken result word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    list_status_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          $error("result word with no operation outstanding");
          failed = 1'b1;
        end else begin
          want = expected_status.pop_front();
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
            failed = 1'b1;
          end
          if (is_empty_o !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty_o);
            failed = 1'b1;
          end
          if (took_effect_o !== want.took_effect) begin
            $error("took_effect: expected %0b, got %0b", want.took_effect, took_effect_o);
            failed = 1'b1;
          end
          if (overflow_o !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow_o);
            failed = 1'b1;
          end
        end
        recv_gap = next_gap(recv_calm);
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [DataW-1:0] pool [8];
    logic [KindW-1:0] k;
    logic signed [DataW-1:0] v;
    int seg, n, j, r, ins_pct;

    // Empty list: removals do nothing; spare codes report state only
    queue_cmd(KindDelFront, 32'sd0);
    queue_cmd(KindDelBack, -32'sd1);
    queue_cmd(KindDelValue, 32'sd0);
    queue_cmd(KindSpareA, 32'sd5);
    // Fill to the brim with extremes and a duplicate pair
    queue_cmd(KindInsFront, 32'sh8000_0000);
    queue_cmd(KindInsBack, 32'sh7fff_ffff);
    queue_cmd(KindInsFront, -32'sd1);
    queue_cmd(KindInsBack, 32'sd0);
    queue_cmd(KindInsBack, 32'sd7);
    queue_cmd(KindInsFront, 32'sd7);
    for (j = 0; j < 10; j++) queue_cmd(j[0] ? KindInsFront : KindInsBack, $urandom);
    // Full list: both inserts are dropped
    queue_cmd(KindInsFront, 32'sd99);
    queue_cmd(KindInsBack, 32'sd99);
    queue_cmd(KindDelValue, 32'sd7);
    queue_cmd(KindDelValue, 32'sd12345);
    queue_cmd(KindSpareC, 32'sh7fff_ffff);

    // Alternate filling and draining phases; values mostly from a small pool
    for (seg = 0; seg < 8; seg++) begin
      for (j = 0; j < 8; j++) begin
        r = $urandom_range(0, 9);
        pool[j] = (r == 0) ? 32'sh8000_0000 : (r == 1) ? 32'sh7fff_ffff : $urandom;
      end
      ins_pct = seg[0] ? 33 : 75;
      for (n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          case ($urandom_range(0, 2))
            0: k = KindSpareA;
            1: k = KindSpareB;
            default: k = KindSpareC;
          endcase
        end else if (r < ins_pct) begin
          k = $urandom_range(0, 1) ? KindInsBack : KindInsFront;
        end else begin
          case ($urandom_range(0, 2))
            0: k = KindDelFront;
            1: k = KindDelBack;
            default: k = KindDelValue;
          endcase
        end
        v = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 7)];
        queue_cmd(k, v);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i); while (pending_cmds.size() != 0 || expected_status.size() != 0);
    repeat (8) @(posedge clk_i);
    if (!failed && expected_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### bounded_list_with_value_delete.f
rtl/blvd_pkg.sv
rtl/blvd_cell.sv
rtl/bounded_list_with_value_delete.sv
rtl/blvd_checker.sv
tb/bounded_list_with_value_delete_tb.sv
